// ===== rtl/sdft_pkg.sv =====
package sdft_pkg;

  localparam int SDFT_ANGLE_BITS = 24;
  localparam int SDFT_OUT_BITS   = 16;

  localparam logic [15:0] DAY_OFFSET_RST = 16'd8035;

  localparam logic [63:0] Q44_ONE = 64'd1 << 44;
  localparam logic [63:0] Q30_ONE = 64'd1 << 30;

  // linear terms of the two angles, fractions of a turn in Q44
  localparam logic [43:0] G_BASE = 44'((64'd35753 * Q44_ONE + 64'd18000) / 64'd36000);
  localparam logic [43:0] L_BASE = 44'((64'd28046 * Q44_ONE + 64'd18000) / 64'd36000);
  localparam logic [35:0] G_RATE =
    36'((64'd98560 * Q44_ONE + 64'd18000000) / 64'd36000000);
  localparam logic [35:0] L_RATE =
    36'((64'd98565 * Q44_ONE + 64'd18000000) / 64'd36000000);

  localparam logic [16:0] SEC_PER_DAY = 17'd86400;

  // rate split as q*86400 + r so the fractional day needs only a narrow divide
  localparam logic [19:0] G_RATE_Q = 20'(64'(G_RATE) / 64'd86400);
  localparam logic [16:0] G_RATE_R = 17'(64'(G_RATE) % 64'd86400);
  localparam logic [19:0] L_RATE_Q = 20'(64'(L_RATE) / 64'd86400);
  localparam logic [16:0] L_RATE_R = 17'(64'(L_RATE) % 64'd86400);

  // exact floor(x/675) for x below 2^26
  localparam int          DIV_SHIFT  = 36;
  localparam logic [26:0] RECIP_675  = 27'(((64'd1 << 36) + 64'd674) / 64'd675);

  localparam logic [32:0] TWO_PI_Q30 = 33'd6746518852;

  localparam logic [22:0] EQ1_Q30 = 23'((64'd1915 * Q30_ONE + 64'd180000) / 64'd360000);
  localparam logic [15:0] EQ2_Q30 = 16'((64'd2 * Q30_ONE + 64'd18000) / 64'd36000);
  localparam logic [29:0] COS_OBL_Q30 = 30'((64'd91748 * Q30_ONE + 64'd50000) / 64'd100000);
  localparam logic [28:0] SIN_OBL_Q30 = 29'((64'd39779 * Q30_ONE + 64'd50000) / 64'd100000);

  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  // horner steps of the series, each a multiply stage and a divide stage
  localparam int SC_STEPS = 4;
  localparam int SC_LAT   = 3 + 2 * (SC_STEPS + 1);

  localparam int STEP_SHIFT [SC_STEPS] = '{37, 36, 35, 34};
  localparam logic [31:0] SIN_RECIP [SC_STEPS] = '{
    32'(((64'd1 << 37) + 64'd71) / 64'd72),
    32'(((64'd1 << 36) + 64'd41) / 64'd42),
    32'(((64'd1 << 35) + 64'd19) / 64'd20),
    32'(((64'd1 << 34) + 64'd5) / 64'd6)
  };
  localparam logic [31:0] COS_RECIP [SC_STEPS] = '{
    32'(((64'd1 << 37) + 64'd89) / 64'd90),
    32'(((64'd1 << 36) + 64'd55) / 64'd56),
    32'(((64'd1 << 35) + 64'd29) / 64'd30),
    32'(((64'd1 << 34) + 64'd11) / 64'd12)
  };

  typedef logic [43:0] turn44_t;
  typedef logic [30:0] mag_t;

  typedef struct packed {
    logic    valid;
    turn44_t g;
    turn44_t l;
  } front_res_t;

  typedef struct packed {
    logic            valid;
    logic [1:0]      neg;
    logic [1:0][30:0] mag;
  } sc_res_t;

endpackage

// ===== rtl/sdft_in_if.sv =====
interface sdft_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] time_seconds;

  modport source (output valid, output time_seconds, input ready);
  modport sink (input valid, input time_seconds, output ready);
endinterface

// ===== rtl/sdft_out_if.sv =====
interface sdft_out_if import sdft_pkg::*; #(
  parameter int OUT_BITS = SDFT_OUT_BITS
);
  logic                       valid;
  logic                       ready;
  logic signed [OUT_BITS-1:0] sun_x;
  logic signed [OUT_BITS-1:0] sun_y;
  logic signed [OUT_BITS-1:0] sun_z;

  modport source (output valid, output sun_x, output sun_y, output sun_z, input ready);
  modport sink (input valid, input sun_x, input sun_y, input sun_z, output ready);
endinterface

// ===== rtl/sdft_cfg_if.sv =====
interface sdft_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] day_offset;

  modport source (output valid, output day_offset, input ready);
  modport sink (input valid, input day_offset, output ready);
endinterface

// ===== rtl/sdft_front.sv =====
module sdft_front import sdft_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  logic       in_valid,
  input  logic [31:0] in_time,
  input  logic [15:0] day_offset,
  output front_res_t res
);

  logic [5:0] vld_r;

  logic [31:0] t1_r;
  logic [51:0] p1_r;
  logic [31:0] t2_r;
  logic [15:0] q2_r;
  logic [32:0] qm2_r;
  logic [16:0] rem3_r;
  logic [16:0] days3_r;
  logic [43:0] gd4_r, ld4_r;
  logic [36:0] gq4_r, lq4_r;
  logic [33:0] gr4_r, lr4_r;
  logic [43:0] gs5_r, ls5_r;
  logic [52:0] gp5_r, lp5_r;
  logic [43:0] g6_r, l6_r;

  logic [52:0] gd_w, ld_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[4:0], in_valid};
    end
  end

  always_comb begin
    gd_w = 53'(G_RATE) * 53'(days3_r);
    ld_w = 53'(L_RATE) * 53'(days3_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // whole days: t/86400 = (t>>7)/675
      t1_r    <= in_time;
      p1_r    <= 52'(in_time[31:7]) * 52'(RECIP_675);
      t2_r    <= t1_r;
      q2_r    <= p1_r[51:36];
      qm2_r   <= 33'(p1_r[51:36]) * 33'(SEC_PER_DAY);
      rem3_r  <= 17'(33'(t2_r) - qm2_r);
      days3_r <= 17'(q2_r) + 17'(day_offset);
      gd4_r   <= gd_w[43:0];
      ld4_r   <= ld_w[43:0];
      gq4_r   <= 37'(G_RATE_Q) * 37'(rem3_r);
      lq4_r   <= 37'(L_RATE_Q) * 37'(rem3_r);
      gr4_r   <= 34'(G_RATE_R) * 34'(rem3_r);
      lr4_r   <= 34'(L_RATE_R) * 34'(rem3_r);
      gs5_r   <= G_BASE + gd4_r + 44'(gq4_r);
      ls5_r   <= L_BASE + ld4_r + 44'(lq4_r);
      gp5_r   <= 53'(gr4_r[33:7]) * 53'(RECIP_675);
      lp5_r   <= 53'(lr4_r[33:7]) * 53'(RECIP_675);
      g6_r    <= gs5_r + 44'(gp5_r >> DIV_SHIFT);
      l6_r    <= ls5_r + 44'(lp5_r >> DIV_SHIFT);
    end
  end

  always_comb begin
    res.valid = vld_r[5];
    res.g     = g6_r;
    res.l     = l6_r;
  end

endmodule

// ===== rtl/sdft_sincos.sv =====
module sdft_sincos import sdft_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [1:0][31:0] in_angle,
  output sc_res_t          res
);

  logic [SC_LAT-1:0] vld_r;

  logic [29:0] red_r  [2];
  logic        cos0_r [2];
  logic        neg0_r [2];
  logic [29:0] x1_r   [2];
  logic        cos1_r [2];
  logic        neg1_r [2];
  logic [29:0] xs_r   [2];
  logic [29:0] x2_r   [2];
  logic        cos2_r [2];
  logic        neg2_r [2];

  logic [29:0] pv_r   [2][SC_STEPS+1];
  logic [29:0] px_r   [2][SC_STEPS+1];
  logic [29:0] px2_r  [2][SC_STEPS+1];
  logic        pcos_r [2][SC_STEPS+1];
  logic        pneg_r [2][SC_STEPS+1];
  logic [30:0] dc_r   [2][SC_STEPS+1];
  logic [29:0] dx_r   [2][SC_STEPS+1];
  logic [29:0] dx2_r  [2][SC_STEPS+1];
  logic        dcos_r [2][SC_STEPS+1];
  logic        dneg_r [2][SC_STEPS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[SC_LAT-2:0], in_valid};
    end
  end

  for (genvar ln = 0; ln < 2; ln++) begin : g_lane
    logic [29:0] r_w;
    logic        big_w;
    logic [62:0] rad_w;
    logic [59:0] sq_w;

    always_comb begin
      r_w   = in_angle[ln][29:0];
      big_w = r_w > 30'h2000_0000;
      rad_w = 63'(red_r[ln]) * 63'(TWO_PI_Q30);
      sq_w  = 60'(x1_r[ln]) * 60'(x1_r[ln]);
    end

    // fold to one eighth of a turn, choosing sine or cosine series
    always_ff @(posedge clk) begin
      if (en) begin
        red_r[ln]  <= big_w ? 30'(31'h4000_0000 - 31'(r_w)) : r_w;
        cos0_r[ln] <= in_angle[ln][30] ^ big_w;
        neg0_r[ln] <= in_angle[ln][31];
        x1_r[ln]   <= rad_w[61:32];
        cos1_r[ln] <= cos0_r[ln];
        neg1_r[ln] <= neg0_r[ln];
        xs_r[ln]   <= x1_r[ln];
        x2_r[ln]   <= sq_w[59:30];
        cos2_r[ln] <= cos1_r[ln];
        neg2_r[ln] <= neg1_r[ln];
      end
    end

    for (genvar j = 0; j <= SC_STEPS; j++) begin : g_step
      logic [30:0] c_in;
      logic [29:0] x_in, x2_in, op_w;
      logic        cos_in, neg_in;
      logic [60:0] pm_w;

      if (j == 0) begin : g_first
        assign c_in   = ONE_Q30;
        assign x_in   = xs_r[ln];
        assign x2_in  = x2_r[ln];
        assign cos_in = cos2_r[ln];
        assign neg_in = neg2_r[ln];
      end else begin : g_next
        assign c_in   = dc_r[ln][j-1];
        assign x_in   = dx_r[ln][j-1];
        assign x2_in  = dx2_r[ln][j-1];
        assign cos_in = dcos_r[ln][j-1];
        assign neg_in = dneg_r[ln][j-1];
      end

      // last sine step multiplies by x instead of x^2
      always_comb begin
        op_w = (j == SC_STEPS && !cos_in) ? x_in : x2_in;
        pm_w = 61'(op_w) * 61'(c_in);
      end

      always_ff @(posedge clk) begin
        if (en) begin
          pv_r[ln][j]   <= pm_w[59:30];
          px_r[ln][j]   <= x_in;
          px2_r[ln][j]  <= x2_in;
          pcos_r[ln][j] <= cos_in;
          pneg_r[ln][j] <= neg_in;
          dx_r[ln][j]   <= px_r[ln][j];
          dx2_r[ln][j]  <= px2_r[ln][j];
          dcos_r[ln][j] <= pcos_r[ln][j];
          dneg_r[ln][j] <= pneg_r[ln][j];
        end
      end

      if (j < SC_STEPS) begin : g_div
        logic [31:0] recip_w;
        logic [61:0] dm_w;
        logic [29:0] q_w;

        always_comb begin
          recip_w = pcos_r[ln][j] ? COS_RECIP[j] : SIN_RECIP[j];
          dm_w    = 62'(pv_r[ln][j]) * 62'(recip_w);
          q_w     = 30'(dm_w >> STEP_SHIFT[j]);
        end

        always_ff @(posedge clk) begin
          if (en) begin
            dc_r[ln][j] <= ONE_Q30 - 31'(q_w);
          end
        end
      end else begin : g_tail
        always_ff @(posedge clk) begin
          if (en) begin
            dc_r[ln][j] <= pcos_r[ln][j] ? ONE_Q30 - 31'(pv_r[ln][j] >> 1)
                                         : 31'(pv_r[ln][j]);
          end
        end
      end
    end
  end

  always_comb begin
    res.valid = vld_r[SC_LAT-1];
    for (int k = 0; k < 2; k++) begin
      res.mag[k] = dc_r[k][SC_STEPS];
      res.neg[k] = dneg_r[k][SC_STEPS];
    end
  end

endmodule

// ===== rtl/sun_direction_from_time_top.sv =====
// channel  dir  handshake      payload
// in_ch    in   valid/ready    time_seconds[31:0]
// out_ch   out  valid/ready    sun_x, sun_y, sun_z [OUT_BITS-1:0] signed
// cfg_ch   in   valid/ready    day_offset[15:0], always ready
//
// one request per cycle while in_ready is high; a result is offered once it has passed
// through the day split, the two serial sine/cosine pipelines and output rounding.
// synchronous active-low reset clears valids and sets day_offset to 8035.
// a stalled output fills the output register, then a skid register; in_ready
// drops only once the skid register holds data and the whole pipeline freezes.
module sun_direction_from_time_top import sdft_pkg::*; #(
  parameter int ANGLE_BITS = SDFT_ANGLE_BITS,
  parameter int OUT_BITS   = SDFT_OUT_BITS
) (
  input logic        clk,
  input logic        rst_n,
  sdft_in_if.sink    in_ch,
  sdft_out_if.source out_ch,
  sdft_cfg_if.sink   cfg_ch
);

  localparam int ASH = 44 - ANGLE_BITS;
  localparam int OSH = 31 - OUT_BITS;
  localparam logic [OUT_BITS:0] MAXV = {2'b00, {(OUT_BITS-1){1'b1}}};
  localparam logic [OUT_BITS:0] MINM = MAXV + 1'b1;

  logic [15:0] day_offset_r;
  logic        en;
  logic        push;

  front_res_t  fr;
  sc_res_t     sc1, sc2;
  logic [1:0][31:0] sc1_ang, sc2_ang;

  logic        a_v_r;
  logic [31:0] ga_r;
  turn44_t     al_r;
  turn44_t     l_dly_r [SC_LAT];

  logic        b1_v_r, b2_v_r, b3_v_r, c1_v_r, fin_v_r;
  logic [37:0] t1_r, t2_r;
  logic        n1_r, n2_r;
  turn44_t     b1_l_r, b2_l_r;
  logic [31:0] la_r, lq_r;
  mag_t        c1_mag_r [3];
  logic        c1_neg_r [3];
  logic [OUT_BITS-1:0] fin_r  [3];
  logic [OUT_BITS-1:0] outd_r [3];
  logic [OUT_BITS-1:0] skid_r [3];
  logic        out_v_r, skid_v_r;

  logic [44:0] g_rnd_w, l_rnd_w;
  logic [ANGLE_BITS-1:0] g_ang_w, l_ang_w;
  logic [53:0] t1_w;
  logic [46:0] t2_w;
  turn44_t     l_a_w, l_b_w;
  logic [60:0] my_w, mz_w;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      day_offset_r <= DAY_OFFSET_RST;
    end else if (cfg_ch.valid) begin
      day_offset_r <= cfg_ch.day_offset;
    end
  end

  assign en          = !skid_v_r;
  assign in_ch.ready = en;
  assign push        = en && fin_v_r;

  sdft_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (in_ch.valid),
    .in_time    (in_ch.time_seconds),
    .day_offset (day_offset_r),
    .res        (fr)
  );

  // round the mean anomaly to the angle width
  always_comb begin
    g_rnd_w = {1'b0, fr.g} + (45'd1 << (ASH - 1));
    g_ang_w = g_rnd_w[ASH +: ANGLE_BITS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ga_r <= 32'(g_ang_w) << (32 - ANGLE_BITS);
      al_r <= fr.l;
      l_dly_r[0] <= al_r;
      for (int i = 1; i < SC_LAT; i++) begin
        l_dly_r[i] <= l_dly_r[i-1];
      end
    end
  end

  assign sc1_ang[0] = ga_r;
  assign sc1_ang[1] = {ga_r[30:0], 1'b0};

  sdft_sincos u_sc_g (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (a_v_r),
    .in_angle (sc1_ang),
    .res      (sc1)
  );

  // equation of center terms, then longitude rounding
  always_comb begin
    t1_w    = 54'(EQ1_Q30) * 54'(sc1.mag[0]);
    t2_w    = 47'(EQ2_Q30) * 47'(sc1.mag[1]);
    l_a_w   = n1_r ? b1_l_r - 44'(t1_r) : b1_l_r + 44'(t1_r);
    l_b_w   = n2_r ? l_a_w - 44'(t2_r) : l_a_w + 44'(t2_r);
    l_rnd_w = {1'b0, b2_l_r} + (45'd1 << (ASH - 1));
    l_ang_w = l_rnd_w[ASH +: ANGLE_BITS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1_r   <= 38'(t1_w >> 16);
      t2_r   <= 38'(t2_w >> 16);
      n1_r   <= sc1.neg[0];
      n2_r   <= sc1.neg[1];
      b1_l_r <= l_dly_r[SC_LAT-1];
      b2_l_r <= l_b_w;
      la_r   <= 32'(l_ang_w) << (32 - ANGLE_BITS);
      lq_r   <= (32'(l_ang_w) << (32 - ANGLE_BITS)) + 32'h4000_0000;
    end
  end

  assign sc2_ang[0] = lq_r;
  assign sc2_ang[1] = la_r;

  sdft_sincos u_sc_l (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (b3_v_r),
    .in_angle (sc2_ang),
    .res      (sc2)
  );

  always_comb begin
    my_w = 61'(sc2.mag[1]) * 61'(COS_OBL_Q30);
    mz_w = 61'(sc2.mag[1]) * 61'(SIN_OBL_Q30);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_mag_r[0] <= sc2.mag[0];
      c1_mag_r[1] <= 31'(my_w >> 30);
      c1_mag_r[2] <= 31'(mz_w >> 30);
      c1_neg_r[0] <= sc2.neg[0];
      c1_neg_r[1] <= sc2.neg[1];
      c1_neg_r[2] <= sc2.neg[1];
    end
  end

  // round half away from zero and saturate
  for (genvar k = 0; k < 3; k++) begin : g_out
    logic [31:0]       sum_w;
    logic [OUT_BITS:0] m_w, mm_w;
    logic [OUT_BITS-1:0] o_w;

    always_comb begin
      sum_w = 32'(c1_mag_r[k]) + (32'd1 << (OSH - 1));
      m_w   = sum_w[31:OSH];
      mm_w  = (m_w > MINM) ? MINM : m_w;
      if (c1_neg_r[k]) begin
        o_w = {OUT_BITS{1'b0}} - mm_w[OUT_BITS-1:0];
      end else begin
        o_w = (m_w > MAXV) ? MAXV[OUT_BITS-1:0] : m_w[OUT_BITS-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        fin_r[k] <= o_w;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r   <= 1'b0;
      b1_v_r  <= 1'b0;
      b2_v_r  <= 1'b0;
      b3_v_r  <= 1'b0;
      c1_v_r  <= 1'b0;
      fin_v_r <= 1'b0;
    end else if (en) begin
      a_v_r   <= fr.valid;
      b1_v_r  <= sc1.valid;
      b2_v_r  <= b1_v_r;
      b3_v_r  <= b2_v_r;
      c1_v_r  <= sc2.valid;
      fin_v_r <= c1_v_r;
    end
  end

  // output register with skid register behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || out_ch.ready) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= push;
      end
    end else if (push) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || out_ch.ready) begin
      if (skid_v_r) begin
        outd_r <= skid_r;
      end else if (push) begin
        outd_r <= fin_r;
      end
    end else if (push) begin
      skid_r <= fin_r;
    end
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.sun_x = outd_r[0];
  assign out_ch.sun_y = outd_r[1];
  assign out_ch.sun_z = outd_r[2];

endmodule
